[sv/cfa_pkg.sv]
// Shared types, constants and the arctangent table of the field angle block.
`timescale 1ns / 1ps
`default_nettype none

package cfa_pkg;

	// Default sizes handed to the top level
	localparam int unsigned CORDIC_STEPS_DEF = 16;
	localparam int unsigned ANGLE_BITS_DEF   = 16;

	// Widths of the field, configuration and working values
	localparam int unsigned FIELD_W = 16;
	localparam int unsigned DIFF_W  = FIELD_W + 1;
	localparam int unsigned PROD_W  = 2 * DIFF_W;
	localparam int unsigned VEC_W   = 36;
	localparam int unsigned ACC_W   = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 16;

	localparam logic [FIELD_W-1:0] SCALE_ONE = 16'd4096;
	localparam logic [ACC_W-1:0]   HALF_TURN = 32'h8000_0000;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_OFFSET    = 3'd0,
		REG_Y_OFFSET    = 3'd1,
		REG_X_SCALE     = 3'd2,
		REG_Y_SCALE     = 3'd3,
		REG_ZERO_ANGLE  = 3'd4,
		REG_REVERSE_DIR = 3'd5
	} cfa_reg_t;

	// Payload that travels down the rotation chain
	typedef struct packed {
		logic                    failed;
		logic                    zero;
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic [ACC_W-1:0]        acc;
	} cfa_item_t;

	// atan(2^-i) as a 32-bit binary angle, truncated
	function automatic logic [ACC_W-1:0] atan_turn(input int unsigned i);
		logic [ACC_W-1:0] r;
		case (i)
			0:  r = 32'h2000_0000;
			1:  r = 32'h12E4_051D;
			2:  r = 32'h09FB_385B;
			3:  r = 32'h0511_11D4;
			4:  r = 32'h028B_0D43;
			5:  r = 32'h0145_D7E1;
			6:  r = 32'h00A2_F61E;
			7:  r = 32'h0051_7C55;
			8:  r = 32'h0028_BE53;
			9:  r = 32'h0014_5F2F;
			10: r = 32'h000A_2F98;
			11: r = 32'h0005_17CC;
			12: r = 32'h0002_8BE6;
			13: r = 32'h0001_45F3;
			14: r = 32'h0000_A2F9;
			15: r = 32'h0000_517C;
			16: r = 32'h0000_28BE;
			17: r = 32'h0000_145F;
			18: r = 32'h0000_0A2F;
			19: r = 32'h0000_0517;
			20: r = 32'h0000_028B;
			21: r = 32'h0000_0145;
			22: r = 32'h0000_00A2;
			23: r = 32'h0000_0051;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[sv/cfa_ifs.sv]
// Handshake interfaces for the sample, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none

interface cfa_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] field_x;
	logic signed [15:0] field_y;
	logic               read_failed;

	modport source (output valid, output field_x, output field_y, output read_failed,
		input ready);
	modport sink (input valid, input field_x, input field_y, input read_failed,
		output ready);
endinterface

interface cfa_out_if #(parameter int unsigned ANGLE_BITS = 16);
	logic                  valid;
	logic                  ready;
	logic [ANGLE_BITS-1:0] angle;
	logic                  failed;

	modport source (output valid, output angle, output failed, input ready);
	modport sink (input valid, input angle, input failed, output ready);
endinterface

interface cfa_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/calibrated_field_angle.sv]
// Top level: calibrated magnetic field angle with a pipelined arctangent chain.
// Path from an accepted sample to its result: three front-end stages,
// one register per rotation cell, a rounding register and the output register.
// Throughput: one item per cycle while the skid stage is empty, set by the chain of rotation cells.
// A stalled result is parked in a skid stage, so input ready is a register.
// Reset (arst_n low) empties the pipeline and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module calibrated_field_angle import cfa_pkg::*; #(
	parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF,
	parameter int unsigned ANGLE_BITS   = ANGLE_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cfa_in_if.sink     sample,
	cfa_out_if.source  result,
	cfa_cfg_if.sink    cfg
);

	logic signed [FIELD_W-1:0] x_offset_q, y_offset_q;
	logic [FIELD_W-1:0]        x_scale_q, y_scale_q, zero_angle_q;
	logic                      reverse_dir_q;
	logic                      adv;
	logic                      vld [CORDIC_STEPS+1];
	cfa_item_t                 item [CORDIC_STEPS+1];

	// Configuration writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_offset_q    <= '0;
			y_offset_q    <= '0;
			x_scale_q     <= SCALE_ONE;
			y_scale_q     <= SCALE_ONE;
			zero_angle_q  <= '0;
			reverse_dir_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfa_reg_t'(cfg.index))
				REG_X_OFFSET:    x_offset_q    <= cfg.data;
				REG_Y_OFFSET:    y_offset_q    <= cfg.data;
				REG_X_SCALE:     x_scale_q     <= cfg.data;
				REG_Y_SCALE:     y_scale_q     <= cfg.data;
				REG_ZERO_ANGLE:  zero_angle_q  <= cfg.data;
				REG_REVERSE_DIR: reverse_dir_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign sample.ready = adv;

	cfa_calib u_calib (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.vld_i       (sample.valid),
		.field_x     (sample.field_x),
		.field_y     (sample.field_y),
		.read_failed (sample.read_failed),
		.x_offset    (x_offset_q),
		.y_offset    (y_offset_q),
		.x_scale     (x_scale_q),
		.y_scale     (y_scale_q),
		.vld_o       (vld[0]),
		.item_o      (item[0])
	);

	// Chain of rotation cells, one step each
	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
		cfa_cell #(.STEP(k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.vld_i  (vld[k]),
			.item_i (item[k]),
			.vld_o  (vld[k+1]),
			.item_o (item[k+1])
		);
	end

	cfa_post #(.ANGLE_BITS(ANGLE_BITS)) u_post (
		.clk         (clk),
		.arst_n      (arst_n),
		.vld_i       (vld[CORDIC_STEPS]),
		.item_i      (item[CORDIC_STEPS]),
		.zero_angle  (ANGLE_BITS'(zero_angle_q)),
		.reverse_dir (reverse_dir_q),
		.adv         (adv),
		.result      (result)
	);

endmodule

`default_nettype wire

[sv/cfa_calib.sv]
// Front end: offset removal, gain multiply and half-turn pre-rotation.
`timescale 1ns / 1ps
`default_nettype none

module cfa_calib import cfa_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      vld_i,
	input  wire logic signed [FIELD_W-1:0] field_x,
	input  wire logic signed [FIELD_W-1:0] field_y,
	input  wire logic                      read_failed,
	input  wire logic signed [FIELD_W-1:0] x_offset,
	input  wire logic signed [FIELD_W-1:0] y_offset,
	input  wire logic [FIELD_W-1:0]        x_scale,
	input  wire logic [FIELD_W-1:0]        y_scale,
	output logic                           vld_o,
	output cfa_item_t                      item_o
);

	logic                     vld_s1, vld_s2, vld_s3;
	logic                     fail_s1, fail_s2;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;
	logic signed [PROD_W-1:0] px_s2, py_s2;
	logic signed [VEC_W-1:0]  vx, vy;
	cfa_item_t                pre;
	cfa_item_t                item_s3;

	// Advance the valid bits with the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Remove hard-iron offsets
	always_ff @(posedge clk) begin
		if (en) begin
			fail_s1 <= read_failed;
			dx_s1   <= DIFF_W'(field_x) - DIFF_W'(x_offset);
			dy_s1   <= DIFF_W'(field_y) - DIFF_W'(y_offset);
		end
	end

	// Apply soft-iron gains at full width
	always_ff @(posedge clk) begin
		if (en) begin
			fail_s2 <= fail_s1;
			px_s2   <= PROD_W'(dx_s1) * PROD_W'($signed({1'b0, x_scale}));
			py_s2   <= PROD_W'(dy_s1) * PROD_W'($signed({1'b0, y_scale}));
		end
	end

	// Rotate a vector with negative X by half a turn
	always_comb begin
		vx         = VEC_W'(px_s2);
		vy         = VEC_W'(py_s2);
		pre.failed = fail_s2;
		pre.zero   = (px_s2 == '0) && (py_s2 == '0);
		if (px_s2 < 0) begin
			pre.x   = -vx;
			pre.y   = -vy;
			pre.acc = HALF_TURN;
		end else begin
			pre.x   = vx;
			pre.y   = vy;
			pre.acc = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s3 <= pre;
		end
	end

	assign vld_o  = vld_s3;
	assign item_o = item_s3;

endmodule

`default_nettype wire

[sv/cfa_cell.sv]
// One vectoring rotation cell of the arctangent chain.
`timescale 1ns / 1ps
`default_nettype none

module cfa_cell import cfa_pkg::*; #(
	parameter int unsigned STEP = 0
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      vld_i,
	input  wire cfa_item_t item_i,
	output logic           vld_o,
	output cfa_item_t      item_o
);

	localparam logic [ACC_W-1:0] ATAN = atan_turn(STEP);

	logic signed [VEC_W-1:0] xs, ys;
	cfa_item_t               nxt;
	logic                    vld_q;
	cfa_item_t               item_q;

	// Rotate towards the X axis by the angle of this step
	always_comb begin
		xs  = $signed(item_i.x) >>> STEP;
		ys  = $signed(item_i.y) >>> STEP;
		nxt = item_i;
		if (!item_i.y[VEC_W-1]) begin
			nxt.x   = item_i.x + ys;
			nxt.y   = item_i.y - xs;
			nxt.acc = item_i.acc + ATAN;
		end else begin
			nxt.x   = item_i.x - ys;
			nxt.y   = item_i.y + xs;
			nxt.acc = item_i.acc - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_q <= nxt;
		end
	end

	assign vld_o  = vld_q;
	assign item_o = item_q;

endmodule

`default_nettype wire

[sv/cfa_post.sv]
// Back end: rounding, zero position, mirror and the output skid stage.
`timescale 1ns / 1ps
`default_nettype none

module cfa_post import cfa_pkg::*; #(
	parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  vld_i,
	input  wire cfa_item_t             item_i,
	input  wire logic [ANGLE_BITS-1:0] zero_angle,
	input  wire logic                  reverse_dir,
	output logic                       adv,
	cfa_out_if.source                  result
);

	localparam logic [ACC_W-1:0] RND = ACC_W'(1) << (ACC_W - 1 - ANGLE_BITS);

	logic [ACC_W-1:0]      rnd;
	logic [ANGLE_BITS-1:0] theta;
	logic                  vld_s1, fail_s1;
	logic [ANGLE_BITS-1:0] theta_s1;
	logic [ANGLE_BITS-1:0] diff, ang;
	logic                  out_v_q, skid_v_q;
	logic [ANGLE_BITS-1:0] out_ang_q, skid_ang_q;
	logic                  out_fail_q, skid_fail_q;

	// The chain moves only while the skid stage is empty
	assign adv = !skid_v_q;

	// Round the turn accumulator to the angle width
	always_comb begin
		rnd   = item_i.acc + RND;
		theta = item_i.zero ? '0 : rnd[ACC_W-1 -: ANGLE_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fail_s1  <= item_i.failed;
			theta_s1 <= theta;
		end
	end

	// Subtract the zero position and mirror; a failed read gives 0
	always_comb begin
		diff = theta_s1 - zero_angle;
		ang  = reverse_dir ? -diff : diff;
		if (fail_s1) begin
			ang = '0;
		end
	end

	// Hold the output and park an item in the skid stage when stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (result.ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || result.ready) begin
			out_v_q <= vld_s1;
		end else if (vld_s1) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (result.ready) begin
				out_ang_q  <= skid_ang_q;
				out_fail_q <= skid_fail_q;
			end
		end else if (!out_v_q || result.ready) begin
			out_ang_q  <= ang;
			out_fail_q <= fail_s1;
		end else begin
			skid_ang_q  <= ang;
			skid_fail_q <= fail_s1;
		end
	end

	assign result.valid  = out_v_q;
	assign result.angle  = out_ang_q;
	assign result.failed = out_fail_q;

`ifndef SYNTH
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_fail_q |-> out_ang_q == '0)
		else $error("failed item with non-zero angle");

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid stage full while output register empty");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && result.ready |=> !skid_v_q && out_v_q)
		else $error("skid stage did not drain into the output register");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!skid_v_q && out_v_q && !result.ready && vld_s1 |=> skid_v_q)
		else $error("stalled item was not parked in the skid stage");
`endif

endmodule

`default_nettype wire

[tb/calibrated_field_angle_tb.sv]
// Self-checking testbench for the calibrated field angle block.
`timescale 1ns / 1ps

module calibrated_field_angle_tb;
	import cfa_pkg::*;

	localparam int unsigned STEPS   = CORDIC_STEPS_DEF;
	localparam int unsigned ABITS   = ANGLE_BITS_DEF;
	localparam int unsigned LATENCY = STEPS + 5;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned BLOCK_ITEMS = 166;
	localparam int unsigned NUM_BLOCKS  = 8;

	// Indexes past the last register; writes to them must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	// Kinds of register setting used per block
	localparam int KIND_MILD    = 0;
	localparam int KIND_HIGH    = 1;
	localparam int KIND_LOW     = 2;
	localparam int KIND_ANY     = 3;

	// atan(2^-i) in 32-bit turns, truncated
	localparam logic [31:0] ARCTAN_TURN [0:23] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	typedef struct packed {
		logic [ABITS-1:0] angle;
		logic             failed;
	} angle_res_t;

	// Angle predictor with its own register copy and the queue of pending angles
	class angle_scoreboard;
		angle_res_t         pending_angles[$];
		logic signed [15:0] x_off;
		logic signed [15:0] y_off;
		logic [15:0]        x_gain;
		logic [15:0]        y_gain;
		logic [15:0]        zero_pos;
		logic               mirror;
		int                 errors;

		function new();
			x_off    = '0;
			y_off    = '0;
			x_gain   = SCALE_ONE;
			y_gain   = SCALE_ONE;
			zero_pos = '0;
			mirror   = 1'b0;
			errors   = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
			case (idx)
				REG_X_OFFSET:    x_off = val;
				REG_Y_OFFSET:    y_off = val;
				REG_X_SCALE:     x_gain = val;
				REG_Y_SCALE:     y_gain = val;
				REG_ZERO_ANGLE:  zero_pos = val;
				REG_REVERSE_DIR: mirror = val[0];
				default: ;
			endcase
		endfunction

		// Vectoring rotation to a 32-bit turn angle
		function logic [31:0] field_turn(longint vx, longint vy);
			logic [31:0] acc;
			longint      sx;
			longint      sy;
			acc = '0;
			if (vx == 0 && vy == 0)
				return acc;
			// fold the left half plane over by half a turn
			if (vx < 0) begin
				vx  = -vx;
				vy  = -vy;
				acc = HALF_TURN;
			end
			for (int i = 0; i < STEPS && i < 24; i++) begin
				sx = vx >>> i;
				sy = vy >>> i;
				if (vy >= 0) begin
					vx  = vx + sy;
					vy  = vy - sx;
					acc = acc + ARCTAN_TURN[i];
				end else begin
					vx  = vx - sy;
					vy  = vy + sx;
					acc = acc - ARCTAN_TURN[i];
				end
			end
			return acc;
		endfunction

		function angle_res_t predict_angle(logic signed [15:0] fx, logic signed [15:0] fy,
			logic rf);
			angle_res_t       r;
			longint           cx;
			longint           cy;
			logic [31:0]      acc;
			logic [31:0]      rounded;
			logic [ABITS-1:0] a;
			r = '0;
			if (rf) begin
				r.failed = 1'b1;
				return r;
			end
			cx = (longint'(fx) - longint'(x_off)) * longint'({1'b0, x_gain});
			cy = (longint'(fy) - longint'(y_off)) * longint'({1'b0, y_gain});
			acc = field_turn(cx, cy);
			rounded = acc + (32'd1 << (31 - ABITS));
			a = rounded[31 -: ABITS];
			a = a - zero_pos[ABITS-1:0];
			if (mirror)
				a = -a;
			r.angle = a;
			return r;
		endfunction

		function void note_sample(logic signed [15:0] fx, logic signed [15:0] fy, logic rf);
			pending_angles.push_back(predict_angle(fx, fy, rf));
		endfunction

		function void check_result(logic [ABITS-1:0] angle, logic failed);
			angle_res_t want;
			if (pending_angles.size() == 0) begin
				$display("%0t unexpected result: expected none, got angle %0d failed %0b",
					$time, angle, failed);
				errors++;
				return;
			end
			want = pending_angles.pop_front();
			if (angle !== want.angle) begin
				$display("%0t angle mismatch: expected %0d, got %0d", $time, want.angle, angle);
				errors++;
			end
			if (failed !== want.failed) begin
				$display("%0t failed mismatch: expected %0b, got %0b", $time, want.failed,
					failed);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   sender_idle_pct;
	int   recv_stall_pct;
	int   quiet_cycles;
	angle_scoreboard sb;

	cfa_in_if                           sample_if ();
	cfa_out_if #(.ANGLE_BITS(ABITS))    result_if ();
	cfa_cfg_if                          cfg_if ();

	calibrated_field_angle #(
		.CORDIC_STEPS(STEPS),
		.ANGLE_BITS(ABITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_if),
		.result(result_if),
		.cfg(cfg_if)
	);

	// Free-running clock, 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the result side at random
	always @(negedge clk) begin
		result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready)
			sb.check_result(result_if.angle, result_if.failed);
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (sample_if.valid && sample_if.ready) ||
				(result_if.valid && result_if.ready) || (cfg_if.valid && cfg_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one item, idling at random first, and hold it until accepted
	task automatic push_sample(input logic signed [15:0] fx, input logic signed [15:0] fy,
		input logic rf);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			sample_if.valid = 1'b0;
			sample_if.field_x = 16'($urandom);
			sample_if.field_y = 16'($urandom);
			sample_if.read_failed = 1'($urandom);
			@(negedge clk);
		end
		sample_if.valid = 1'b1;
		sample_if.field_x = fx;
		sample_if.field_y = fy;
		sample_if.read_failed = rf;
		do @(posedge clk); while (!sample_if.ready);
		sb.note_sample(fx, fy, rf);
	endtask

	// Drop valid and wait until every pending angle has come back
	task automatic hold_samples();
		@(negedge clk);
		sample_if.valid = 1'b0;
		while (sb.pending_angles.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		hold_samples();
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data = val;
		do @(posedge clk); while (!cfg_if.ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic apply_setting(input int kind);
		case (kind)
			KIND_HIGH: begin
				write_cfg(REG_X_OFFSET, 16'h7FFF);
				write_cfg(REG_Y_OFFSET, 16'h8000);
				write_cfg(REG_X_SCALE, 16'hFFFF);
				write_cfg(REG_Y_SCALE, 16'hFFFF);
				write_cfg(REG_ZERO_ANGLE, 16'hFFFF);
				write_cfg(REG_REVERSE_DIR, 16'h0001);
			end
			KIND_LOW: begin
				write_cfg(REG_X_OFFSET, 16'h8000);
				write_cfg(REG_Y_OFFSET, 16'h7FFF);
				write_cfg(REG_X_SCALE, 16'h0000);
				write_cfg(REG_Y_SCALE, 16'h0001);
				write_cfg(REG_ZERO_ANGLE, 16'h0000);
				write_cfg(REG_REVERSE_DIR, 16'h0000);
			end
			KIND_ANY: begin
				write_cfg(REG_X_OFFSET, 16'($urandom));
				write_cfg(REG_Y_OFFSET, 16'($urandom));
				write_cfg(REG_X_SCALE, 16'($urandom));
				write_cfg(REG_Y_SCALE, 16'($urandom));
				write_cfg(REG_ZERO_ANGLE, 16'($urandom));
				write_cfg(REG_REVERSE_DIR, 16'($urandom));
			end
			default: begin
				write_cfg(REG_X_OFFSET, 16'($urandom_range(4095) - 2048));
				write_cfg(REG_Y_OFFSET, 16'($urandom_range(4095) - 2048));
				write_cfg(REG_X_SCALE, 16'($urandom_range(8191, 2048)));
				write_cfg(REG_Y_SCALE, 16'($urandom_range(8191, 2048)));
				write_cfg(REG_ZERO_ANGLE, 16'($urandom));
				write_cfg(REG_REVERSE_DIR, 16'($urandom_range(1)));
			end
		endcase
	endtask

	function automatic logic signed [15:0] edge_value();
		case ($urandom_range(3))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			default: return 16'shFFFF;
		endcase
	endfunction

	// Random item: mostly full range, some near the offsets and some at the extremes
	task automatic push_random();
		logic signed [15:0] fx;
		logic signed [15:0] fy;
		logic               rf;
		rf = ($urandom_range(9) == 0);
		case ($urandom_range(9))
			0: begin
				fx = sb.x_off;
				fy = sb.y_off;
			end
			1: begin
				fx = sb.x_off + $signed(16'($urandom_range(16))) - 16'sd8;
				fy = sb.y_off + $signed(16'($urandom_range(16))) - 16'sd8;
			end
			2: begin
				fx = edge_value();
				fy = edge_value();
			end
			default: begin
				fx = 16'($urandom);
				fy = 16'($urandom);
			end
		endcase
		push_sample(fx, fy, rf);
	endtask

	initial begin
		int kinds [NUM_BLOCKS];
		clk = 1'b0;
		arst_n = 1'b0;
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		quiet_cycles = 0;
		sample_if.valid = 1'b0;
		sample_if.field_x = '0;
		sample_if.field_y = '0;
		sample_if.read_failed = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		result_if.ready = 1'b0;
		sb = new();
		kinds = '{KIND_MILD, KIND_ANY, KIND_HIGH, KIND_MILD, KIND_LOW, KIND_ANY,
			KIND_MILD, KIND_ANY};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, quadrants, axes, zero vector, failed reads
		push_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
		push_sample(16'sh8000, 16'sh8000, 1'b0);
		push_sample(16'sh7FFF, 16'sh8000, 1'b0);
		push_sample(16'sh8000, 16'sh7FFF, 1'b0);
		push_sample(16'sh0000, 16'sh0000, 1'b0);
		push_sample(16'sh0001, 16'sh0000, 1'b0);
		push_sample(16'shFFFF, 16'sh0000, 1'b0);
		push_sample(16'sh0000, 16'sh0001, 1'b0);
		push_sample(16'sh0000, 16'shFFFF, 1'b0);
		push_sample(16'sh8000, 16'sh0000, 1'b0);
		push_sample(16'shFFFF, 16'shFFFF, 1'b0);
		push_sample(16'sh7FFF, 16'sh7FFF, 1'b1);
		push_sample(16'sh8000, 16'sh0000, 1'b1);

		// Spare indexes are dropped; only bit 0 of the direction register counts
		write_cfg(REG_SPARE_A, 16'hFFFF);
		write_cfg(REG_SPARE_B, 16'hFFFF);
		write_cfg(REG_REVERSE_DIR, 16'hFFFE);
		push_sample(16'sh1234, 16'sh0567, 1'b0);
		write_cfg(REG_REVERSE_DIR, 16'hFFFF);
		write_cfg(REG_ZERO_ANGLE, 16'h8000);
		push_sample(16'sh1234, 16'sh0567, 1'b0);
		push_sample(16'sh0000, 16'sh0000, 1'b0);

		// Zero vector through offsets, then wide products
		apply_setting(KIND_HIGH);
		push_sample(16'sh7FFF, 16'sh8000, 1'b0);
		push_sample(16'sh8000, 16'sh7FFF, 1'b0);
		push_sample(16'sh0000, 16'sh0000, 1'b0);
		apply_setting(KIND_LOW);
		push_sample(16'sh7FFF, 16'sh8000, 1'b0);
		push_sample(16'sh1000, 16'sh7FFF, 1'b0);

		// Random blocks, each with its own setting and idling pattern
		for (int b = 0; b < NUM_BLOCKS; b++) begin
			apply_setting(kinds[b]);
			case (b % 4)
				0: begin
					sender_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 73;
					recv_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					recv_stall_pct = 73;
				end
				default: begin
					sender_idle_pct = 22;
					recv_stall_pct = 22;
				end
			endcase
			for (int i = 0; i < BLOCK_ITEMS; i++) begin
				// pause mid-block until the pipeline has emptied
				if (i == BLOCK_ITEMS / 2)
					hold_samples();
				push_random();
			end
		end

		// Drain, then watch for stray results
		hold_samples();
		recv_stall_pct = 0;
		repeat (2 * LATENCY) @(posedge clk);
		if (sb.errors == 0 && sb.pending_angles.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
